// File: src/cdq_pkg.sv
// Package: frame geometry, derived widths and shared types for the crop/downscale/quantize block
package cdq_pkg;

  localparam int SOURCE_WIDTH = 320;
  localparam int CROP_SIZE    = 240;
  localparam int OUTPUT_SIZE  = 128;

  // left edge of the centered square; zero when the source is narrower than the crop
  localparam int X0 = (SOURCE_WIDTH >= CROP_SIZE) ? (SOURCE_WIDTH - CROP_SIZE) / 2 : 0;

  // per-output step of the source target, as quotient and remainder of CROP/OUTPUT
  localparam int STEP_Q = CROP_SIZE / OUTPUT_SIZE;
  localparam int STEP_R = CROP_SIZE % OUTPUT_SIZE;

  localparam int COL_MAX = (X0 + CROP_SIZE > SOURCE_WIDTH) ? X0 + CROP_SIZE : SOURCE_WIDTH;
  localparam int COL_W   = $clog2(COL_MAX + 1);
  localparam int ROW_W   = $clog2(CROP_SIZE + 1);
  localparam int OCOL_W  = $clog2(OUTPUT_SIZE);
  localparam int OROW_W  = $clog2(OUTPUT_SIZE + 1);
  localparam int REM_W   = $clog2(OUTPUT_SIZE);

  localparam int PIX_W   = 8;
  localparam int GAIN_W  = 24;
  localparam int ZP_W    = 8;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = GAIN_W;

  // configuration register indexes
  localparam logic CFG_GAIN   = 1'b0;
  localparam logic CFG_OFFSET = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(65536);
  localparam logic [ZP_W-1:0]   ZP_RST   = ZP_W'(8'h80);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } cdq_kept_t;

endpackage

// File: src/cdq_if.sv
// Stream interfaces: source pixel words in, quantized words out
interface cdq_in_if;
  logic                      valid;
  logic                      ready;
  logic [cdq_pkg::PIX_W-1:0] pixel;
  logic                      frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface cdq_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] quantized;
  logic              last_of_frame;

  modport source (output valid, output quantized, output last_of_frame, input ready);
  modport sink   (input valid, input quantized, input last_of_frame, output ready);
endinterface

// File: src/cdq_cfg.sv
// Configuration registers: gain and zero point
module cdq_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [cdq_pkg::CFG_W-1:0]  cfg_data,
  output logic [cdq_pkg::GAIN_W-1:0] gain,
  output logic signed [cdq_pkg::ZP_W-1:0] q_offset
);

  logic [cdq_pkg::GAIN_W-1:0] gain_r;
  logic [cdq_pkg::ZP_W-1:0]   zp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= cdq_pkg::GAIN_RST;
      zp_r   <= cdq_pkg::ZP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdq_pkg::CFG_GAIN:   gain_r <= cfg_data[cdq_pkg::GAIN_W-1:0];
        cdq_pkg::CFG_OFFSET: zp_r   <= cfg_data[cdq_pkg::ZP_W-1:0];
        default: ;
      endcase
    end
  end

  assign gain     = gain_r;
  assign q_offset = signed'(zp_r);

endmodule

// File: src/cdq_scan.sv
// Raster position tracking, kept-pixel decision and input register
module cdq_scan (
  input  logic               clk,
  input  logic               rst_n,
  cdq_in_if.sink             in_chan,
  input  logic               advance,
  output logic               kept_valid,
  output cdq_pkg::cdq_kept_t kept
);

  localparam logic [cdq_pkg::COL_W-1:0]  SW_LAST  = cdq_pkg::COL_W'(cdq_pkg::SOURCE_WIDTH - 1);
  localparam logic [cdq_pkg::COL_W-1:0]  X0_C     = cdq_pkg::COL_W'(cdq_pkg::X0);
  localparam logic [cdq_pkg::COL_W-1:0]  QCOL_C   = cdq_pkg::COL_W'(cdq_pkg::STEP_Q);
  localparam logic [cdq_pkg::ROW_W-1:0]  QROW_C   = cdq_pkg::ROW_W'(cdq_pkg::STEP_Q);
  localparam logic [cdq_pkg::ROW_W-1:0]  CROP_C   = cdq_pkg::ROW_W'(cdq_pkg::CROP_SIZE);
  localparam logic [cdq_pkg::OROW_W-1:0] OROW_END = cdq_pkg::OROW_W'(cdq_pkg::OUTPUT_SIZE);
  localparam logic [cdq_pkg::OROW_W-1:0] OROW_LST = cdq_pkg::OROW_W'(cdq_pkg::OUTPUT_SIZE - 1);
  localparam logic [cdq_pkg::OCOL_W-1:0] OCOL_LST = cdq_pkg::OCOL_W'(cdq_pkg::OUTPUT_SIZE - 1);
  localparam logic [cdq_pkg::REM_W:0]    STEP_R_C = (cdq_pkg::REM_W+1)'(cdq_pkg::STEP_R);
  localparam logic [cdq_pkg::REM_W:0]    OUT_C    = (cdq_pkg::REM_W+1)'(cdq_pkg::OUTPUT_SIZE);

  logic [cdq_pkg::COL_W-1:0]  scol_r, scol_nxt, scol_e;
  logic [cdq_pkg::ROW_W-1:0]  srow_r, srow_nxt, srow_e;
  logic [cdq_pkg::OCOL_W-1:0] ocol_r, ocol_nxt, ocol_e;
  logic [cdq_pkg::OROW_W-1:0] orow_r, orow_nxt, orow_e;
  // target source position of the next output, kept incrementally
  logic [cdq_pkg::COL_W-1:0]  tcol_r, tcol_nxt, tcol_e;
  logic [cdq_pkg::ROW_W-1:0]  trow_r, trow_nxt, trow_e;
  logic [cdq_pkg::REM_W-1:0]  crem_r, crem_nxt, crem_e;
  logic [cdq_pkg::REM_W-1:0]  rrem_r, rrem_nxt, rrem_e;
  logic [cdq_pkg::REM_W:0]    csum, rsum;
  logic                       ccarry, rcarry;

  logic               active, hit, last, accept;
  logic               kept_valid_r;
  cdq_pkg::cdq_kept_t kept_r;

  assign in_chan.ready = !kept_valid_r || advance;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    if (in_chan.frame_start) begin
      scol_e = '0;
      srow_e = '0;
      ocol_e = '0;
      orow_e = '0;
      tcol_e = X0_C;
      trow_e = '0;
      crem_e = '0;
      rrem_e = '0;
    end else begin
      scol_e = scol_r;
      srow_e = srow_r;
      ocol_e = ocol_r;
      orow_e = orow_r;
      tcol_e = tcol_r;
      trow_e = trow_r;
      crem_e = crem_r;
      rrem_e = rrem_r;
    end

    active = srow_e < CROP_C;
    hit    = active && (orow_e < OROW_END) &&
             ((srow_e > trow_e) || ((srow_e == trow_e) && (scol_e >= tcol_e)));
    last   = (orow_e == OROW_LST) && (ocol_e == OCOL_LST);

    csum   = {1'b0, crem_e} + STEP_R_C;
    ccarry = csum >= OUT_C;
    rsum   = {1'b0, rrem_e} + STEP_R_C;
    rcarry = rsum >= OUT_C;

    scol_nxt = scol_e;
    srow_nxt = srow_e;
    ocol_nxt = ocol_e;
    orow_nxt = orow_e;
    tcol_nxt = tcol_e;
    trow_nxt = trow_e;
    crem_nxt = crem_e;
    rrem_nxt = rrem_e;

    if (hit) begin
      if (ocol_e == OCOL_LST) begin
        ocol_nxt = '0;
        tcol_nxt = X0_C;
        crem_nxt = '0;
        orow_nxt = orow_e + 1'b1;
        trow_nxt = trow_e + QROW_C + cdq_pkg::ROW_W'(rcarry);
        rrem_nxt = rcarry ? cdq_pkg::REM_W'(rsum - OUT_C) : cdq_pkg::REM_W'(rsum);
      end else begin
        ocol_nxt = ocol_e + 1'b1;
        tcol_nxt = tcol_e + QCOL_C + cdq_pkg::COL_W'(ccarry);
        crem_nxt = ccarry ? cdq_pkg::REM_W'(csum - OUT_C) : cdq_pkg::REM_W'(csum);
      end
    end

    if (active) begin
      if (scol_e == SW_LAST) begin
        scol_nxt = '0;
        srow_nxt = srow_e + 1'b1;
      end else begin
        scol_nxt = scol_e + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scol_r <= '0;
      srow_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      tcol_r <= X0_C;
      trow_r <= '0;
      crem_r <= '0;
      rrem_r <= '0;
    end else if (accept) begin
      scol_r <= scol_nxt;
      srow_r <= srow_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      tcol_r <= tcol_nxt;
      trow_r <= trow_nxt;
      crem_r <= crem_nxt;
      rrem_r <= rrem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      kept_valid_r <= accept && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      kept_r.pixel <= in_chan.pixel;
      kept_r.last  <= last;
    end
  end

  assign kept_valid = kept_valid_r;
  assign kept       = kept_r;

`ifndef ASSERT_OFF
  a_scol_range: assert property (@(posedge clk) disable iff (!rst_n)
    scol_r <= SW_LAST)
    else $error("source column past line end");
  a_orow_range: assert property (@(posedge clk) disable iff (!rst_n)
    orow_r <= OROW_END)
    else $error("output row past frame end");
  a_hit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && hit) |=> kept_valid_r)
    else $error("kept pixel lost at input register");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (kept_valid_r && !advance) |=> (kept_valid_r && $stable(kept_r)))
    else $error("input register changed while stalled");
`endif

endmodule

// File: src/cdq_quant.sv
// Int8 quantizer: pixel*gain + q_offset in Q16, truncate toward zero, saturate; result register
module cdq_quant (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             kept_valid,
  input  cdq_pkg::cdq_kept_t               kept,
  input  logic [cdq_pkg::GAIN_W-1:0]       gain,
  input  logic signed [cdq_pkg::ZP_W-1:0]  q_offset,
  output logic                             advance,
  cdq_out_if.source                        out_chan
);

  localparam int PROD_W = cdq_pkg::PIX_W + cdq_pkg::GAIN_W;
  localparam int T_W    = PROD_W + 2;
  localparam int Q_W    = T_W - cdq_pkg::FRAC_W;

  logic [PROD_W-1:0]      prod;
  logic signed [T_W-1:0]  t, tb;
  logic signed [Q_W-1:0]  q;
  logic signed [7:0]      sat;

  logic                   out_valid_r;
  logic signed [7:0]      quant_r;
  logic                   last_r;

  always_comb begin
    prod = PROD_W'(kept.pixel) * PROD_W'(gain);
    t    = signed'({2'b00, prod}) +
           signed'({{(T_W-cdq_pkg::ZP_W-cdq_pkg::FRAC_W){q_offset[cdq_pkg::ZP_W-1]}},
                    q_offset, {cdq_pkg::FRAC_W{1'b0}}});
    // bias negatives so the arithmetic shift rounds toward zero
    tb   = t + (t[T_W-1] ? signed'(T_W'({cdq_pkg::FRAC_W{1'b1}})) : signed'(T_W'(0)));
    q    = tb[T_W-1:cdq_pkg::FRAC_W];
    if (q > signed'(Q_W'(127))) begin
      sat = 8'sd127;
    end else if (q < signed'(-Q_W'(128))) begin
      sat = -8'sd128;
    end else begin
      sat = q[7:0];
    end
  end

  assign advance = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= kept_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && kept_valid) begin
      quant_r <= sat;
      last_r  <= kept.last;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.quantized     = quant_r;
  assign out_chan.last_of_frame = last_r;

endmodule

// File: src/crop_downscale_quantize.sv
// Top level: center crop, nearest-neighbor downscale and int8 quantize of a pixel stream
//
//  port      dir  kind          payload
//  in_chan   in   valid/ready   pixel[7:0], frame_start
//  out_chan  out  valid/ready   quantized[7:0] signed, last_of_frame
//  cfg_*     in   write only    index 0 gain[23:0], index 1 q_offset[7:0]
//
// One word accepted per cycle while out_chan does not stall; a kept pixel passes the input register,
// then multiply/saturate into the result register, before it is valid on out_chan.
// Dropped pixels are accepted and give no word.
// rst_n is synchronous: counters clear, gain = 1.0, q_offset = -128.
// A stall on out_chan propagates back through the input register to in_chan.ready.
module crop_downscale_quantize (
  input  logic                      clk,
  input  logic                      rst_n,
  cdq_in_if.sink                    in_chan,
  cdq_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [cdq_pkg::CFG_W-1:0] cfg_data
);

  logic [cdq_pkg::GAIN_W-1:0]      gain;
  logic signed [cdq_pkg::ZP_W-1:0] q_offset;
  logic                            advance;
  logic                            kept_valid;
  cdq_pkg::cdq_kept_t              kept;

  cdq_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .gain       (gain),
    .q_offset   (q_offset)
  );

  cdq_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .advance    (advance),
    .kept_valid (kept_valid),
    .kept       (kept)
  );

  cdq_quant u_quant (
    .clk        (clk),
    .rst_n      (rst_n),
    .kept_valid (kept_valid),
    .kept       (kept),
    .gain       (gain),
    .q_offset   (q_offset),
    .advance    (advance),
    .out_chan   (out_chan)
  );

endmodule
